[hdl/tgr_pkg.sv]
package tgr_pkg;

  // Default screen geometry in pixels.
  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 128;

  // Font geometry: 5 columns of 7 dots, walked column by column.
  localparam int FONT_ROWS   = 7;
  localparam int GLYPH_DOTS  = 35;
  localparam logic [5:0] LAST_DOT    = 6'(GLYPH_DOTS - 1);
  localparam logic [2:0] LAST_ROW    = 3'(FONT_ROWS - 1);

  // Character codes.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  // Font slot of the question mark, used for unprintable codes.
  localparam logic [6:0] GLYPH_FALLBACK = 7'h1F;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FG_COLOR    = 2'd0,
    REG_BG_COLOR    = 2'd1,
    REG_TEXT_SCALE  = 2'd2,
    REG_WRAP_ENABLE = 2'd3
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DRAW,
    ST_FLUSH,
    ST_ADV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic prep;
    logic draw;
    logic flush;
    logic adv;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic visible;
    logic step_ok;
    logic last_dot;
    logic flush_done;
  } sts_t;

  // Packs five font columns into one word, column 0 in the lowest bits.
  function automatic logic [34:0] glyph_pack(input logic [6:0] c0, input logic [6:0] c1,
                                              input logic [6:0] c2, input logic [6:0] c3,
                                              input logic [6:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // 5x7 font for space through tilde; bit 0 of each column is the top row.
  function automatic logic [34:0] glyph_bits(input logic [6:0] idx);
    logic [34:0] g;
    case (idx)
      7'd0:  g = glyph_pack(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
      7'd1:  g = glyph_pack(7'h00, 7'h00, 7'h5F, 7'h00, 7'h00);
      7'd2:  g = glyph_pack(7'h00, 7'h07, 7'h00, 7'h07, 7'h00);
      7'd3:  g = glyph_pack(7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14);
      7'd4:  g = glyph_pack(7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12);
      7'd5:  g = glyph_pack(7'h23, 7'h13, 7'h08, 7'h64, 7'h62);
      7'd6:  g = glyph_pack(7'h36, 7'h49, 7'h56, 7'h20, 7'h50);
      7'd7:  g = glyph_pack(7'h00, 7'h08, 7'h07, 7'h03, 7'h00);
      7'd8:  g = glyph_pack(7'h00, 7'h1C, 7'h22, 7'h41, 7'h00);
      7'd9:  g = glyph_pack(7'h00, 7'h41, 7'h22, 7'h1C, 7'h00);
      7'd10: g = glyph_pack(7'h2A, 7'h1C, 7'h7F, 7'h1C, 7'h2A);
      7'd11: g = glyph_pack(7'h08, 7'h08, 7'h3E, 7'h08, 7'h08);
      7'd12: g = glyph_pack(7'h00, 7'h00, 7'h70, 7'h30, 7'h00);
      7'd13: g = glyph_pack(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
      7'd14: g = glyph_pack(7'h00, 7'h00, 7'h60, 7'h60, 7'h00);
      7'd15: g = glyph_pack(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
      7'd16: g = glyph_pack(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
      7'd17: g = glyph_pack(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
      7'd18: g = glyph_pack(7'h72, 7'h49, 7'h49, 7'h49, 7'h46);
      7'd19: g = glyph_pack(7'h21, 7'h41, 7'h49, 7'h4D, 7'h33);
      7'd20: g = glyph_pack(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
      7'd21: g = glyph_pack(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      7'd22: g = glyph_pack(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h31);
      7'd23: g = glyph_pack(7'h41, 7'h21, 7'h11, 7'h09, 7'h07);
      7'd24: g = glyph_pack(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      7'd25: g = glyph_pack(7'h46, 7'h49, 7'h49, 7'h29, 7'h1E);
      7'd26: g = glyph_pack(7'h00, 7'h00, 7'h14, 7'h00, 7'h00);
      7'd27: g = glyph_pack(7'h00, 7'h40, 7'h34, 7'h00, 7'h00);
      7'd28: g = glyph_pack(7'h00, 7'h08, 7'h14, 7'h22, 7'h41);
      7'd29: g = glyph_pack(7'h14, 7'h14, 7'h14, 7'h14, 7'h14);
      7'd30: g = glyph_pack(7'h00, 7'h41, 7'h22, 7'h14, 7'h08);
      7'd31: g = glyph_pack(7'h02, 7'h01, 7'h59, 7'h09, 7'h06);
      7'd32: g = glyph_pack(7'h3E, 7'h41, 7'h5D, 7'h59, 7'h4E);
      7'd33: g = glyph_pack(7'h7C, 7'h12, 7'h11, 7'h12, 7'h7C);
      7'd34: g = glyph_pack(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
      7'd35: g = glyph_pack(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
      7'd36: g = glyph_pack(7'h7F, 7'h41, 7'h41, 7'h41, 7'h3E);
      7'd37: g = glyph_pack(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
      7'd38: g = glyph_pack(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
      7'd39: g = glyph_pack(7'h3E, 7'h41, 7'h41, 7'h51, 7'h73);
      7'd40: g = glyph_pack(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
      7'd41: g = glyph_pack(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
      7'd42: g = glyph_pack(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
      7'd43: g = glyph_pack(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
      7'd44: g = glyph_pack(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
      7'd45: g = glyph_pack(7'h7F, 7'h02, 7'h1C, 7'h02, 7'h7F);
      7'd46: g = glyph_pack(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
      7'd47: g = glyph_pack(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
      7'd48: g = glyph_pack(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
      7'd49: g = glyph_pack(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
      7'd50: g = glyph_pack(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
      7'd51: g = glyph_pack(7'h26, 7'h49, 7'h49, 7'h49, 7'h32);
      7'd52: g = glyph_pack(7'h03, 7'h01, 7'h7F, 7'h01, 7'h03);
      7'd53: g = glyph_pack(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
      7'd54: g = glyph_pack(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
      7'd55: g = glyph_pack(7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F);
      7'd56: g = glyph_pack(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      7'd57: g = glyph_pack(7'h03, 7'h04, 7'h78, 7'h04, 7'h03);
      7'd58: g = glyph_pack(7'h61, 7'h59, 7'h49, 7'h4D, 7'h43);
      7'd59: g = glyph_pack(7'h00, 7'h7F, 7'h41, 7'h41, 7'h41);
      7'd60: g = glyph_pack(7'h02, 7'h04, 7'h08, 7'h10, 7'h20);
      7'd61: g = glyph_pack(7'h00, 7'h41, 7'h41, 7'h41, 7'h7F);
      7'd62: g = glyph_pack(7'h04, 7'h02, 7'h01, 7'h02, 7'h04);
      7'd63: g = glyph_pack(7'h40, 7'h40, 7'h40, 7'h40, 7'h40);
      7'd64: g = glyph_pack(7'h00, 7'h03, 7'h07, 7'h08, 7'h00);
      7'd65: g = glyph_pack(7'h20, 7'h54, 7'h54, 7'h78, 7'h40);
      7'd66: g = glyph_pack(7'h7F, 7'h28, 7'h44, 7'h44, 7'h38);
      7'd67: g = glyph_pack(7'h38, 7'h44, 7'h44, 7'h44, 7'h28);
      7'd68: g = glyph_pack(7'h38, 7'h44, 7'h44, 7'h28, 7'h7F);
      7'd69: g = glyph_pack(7'h38, 7'h54, 7'h54, 7'h54, 7'h18);
      7'd70: g = glyph_pack(7'h00, 7'h08, 7'h7E, 7'h09, 7'h02);
      7'd71: g = glyph_pack(7'h18, 7'h24, 7'h24, 7'h1C, 7'h78);
      7'd72: g = glyph_pack(7'h7F, 7'h08, 7'h04, 7'h04, 7'h78);
      7'd73: g = glyph_pack(7'h00, 7'h44, 7'h7D, 7'h40, 7'h00);
      7'd74: g = glyph_pack(7'h20, 7'h40, 7'h40, 7'h3D, 7'h00);
      7'd75: g = glyph_pack(7'h7F, 7'h10, 7'h28, 7'h44, 7'h00);
      7'd76: g = glyph_pack(7'h00, 7'h41, 7'h7F, 7'h40, 7'h00);
      7'd77: g = glyph_pack(7'h7C, 7'h04, 7'h78, 7'h04, 7'h78);
      7'd78: g = glyph_pack(7'h7C, 7'h08, 7'h04, 7'h04, 7'h78);
      7'd79: g = glyph_pack(7'h38, 7'h44, 7'h44, 7'h44, 7'h38);
      7'd80: g = glyph_pack(7'h7C, 7'h18, 7'h24, 7'h24, 7'h18);
      7'd81: g = glyph_pack(7'h18, 7'h24, 7'h24, 7'h18, 7'h7C);
      7'd82: g = glyph_pack(7'h7C, 7'h08, 7'h04, 7'h04, 7'h08);
      7'd83: g = glyph_pack(7'h48, 7'h54, 7'h54, 7'h54, 7'h24);
      7'd84: g = glyph_pack(7'h04, 7'h04, 7'h3F, 7'h44, 7'h24);
      7'd85: g = glyph_pack(7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C);
      7'd86: g = glyph_pack(7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C);
      7'd87: g = glyph_pack(7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C);
      7'd88: g = glyph_pack(7'h44, 7'h28, 7'h10, 7'h28, 7'h44);
      7'd89: g = glyph_pack(7'h4C, 7'h10, 7'h10, 7'h10, 7'h7C);
      7'd90: g = glyph_pack(7'h44, 7'h64, 7'h54, 7'h4C, 7'h44);
      7'd91: g = glyph_pack(7'h00, 7'h08, 7'h36, 7'h41, 7'h00);
      7'd92: g = glyph_pack(7'h00, 7'h00, 7'h77, 7'h00, 7'h00);
      7'd93: g = glyph_pack(7'h00, 7'h41, 7'h36, 7'h08, 7'h00);
      7'd94: g = glyph_pack(7'h02, 7'h01, 7'h02, 7'h04, 7'h02);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[hdl/text_glyph_rasterizer_unit.sv]
// Channel  Direction  Signals                     Contents
// in_      slave      tvalid tready tdata tuser   tdata: char_code, start_x, start_y;
//                                                 tuser: start_req
// out_     master     tvalid tready tdata tlast   tdata: rect_x, rect_y, rect_width,
//                                                 rect_height, rect_color; tlast: last
// cfg_     write      we addr wdata               fg_color, bg_color, text_scale,
//                                                 wrap_enable
//
// A drawn character goes through accept, wrap check and font fetch, one font dot
// per cycle over the 35 dots, a flush of the held last rectangle, and the cursor advance.
// A space skipped at a wrap ends at the wrap check; a glyph starting off screen goes to the advance.
// The dot walk in the datapath sets the rate; one rectangle is held back so that the
// last one of a character can be tagged, and a stalled output pauses the walk.
// Reset is synchronous and active low; it clears the cursor and restores the registers.
module text_glyph_rasterizer_unit
  import tgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Character input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], start_x[15:8], start_y[23:16]
  input  logic        in_tuser,   // start_req[0]
  // Rectangle output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // rect_x[7:0], rect_y[14:8], rect_width[18:15],
                                  // rect_height[22:19], rect_color[38:23], zero[39]
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cursor, font and rectangle datapath.
  tgr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/tgr_ctrl.sv]
module tgr_ctrl
  import tgr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.skip) begin
          state_nxt = ST_IDLE;
        end else if (sts.visible) begin
          state_nxt = ST_DRAW;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_DRAW: begin
        if (sts.step_ok && sts.last_dot) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.flush_done) begin
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_DRAW: begin
        cmd.draw = 1'b1;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      ST_ADV: begin
        cmd.adv = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/tgr_datapath.sv]
module tgr_datapath
  import tgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  localparam logic [8:0] SW9 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] SH9 = 9'(SCREEN_HEIGHT);
  localparam logic [7:0] SW8 = 8'(SCREEN_WIDTH);
  localparam logic [7:0] SH8 = 8'(SCREEN_HEIGHT);

  typedef struct packed {
    logic [15:0] color;
    logic [3:0]  h;
    logic [3:0]  w;
    logic [6:0]  y;
    logic [7:0]  x;
  } rect_t;

  // Configuration registers.
  logic [15:0] fg_r;
  logic [15:0] bg_r;
  logic [3:0]  scale_r;
  logic        wrap_r;

  // Cursor and per-character state.
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [7:0]  code_r;
  logic [34:0] gbits_r;
  logic [8:0]  px_r;
  logic [8:0]  py_r;
  logic [5:0]  dot_r;
  logic [2:0]  dotrow_r;

  // One rectangle held back until it is known whether it is the last one.
  logic        pend_v_r;
  rect_t       pend_r;

  // Output register.
  logic        out_v_r;
  rect_t       out_r;
  logic        out_last_r;

  logic [3:0]  s;
  logic [6:0]  s5, s6, s7p3;
  logic [8:0]  col_sum, row_sum, adv_sum;
  logic        wrap_hit;
  logic [7:0]  row_wr, col_eff, row_eff;
  logic [6:0]  glyph_idx;
  logic        dot_bit, have_color, on_screen, cand;
  logic [8:0]  wrem, hrem;
  rect_t       cand_rect;
  logic        out_free, step, flush_emit, out_load;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r    <= 16'hFFFF;
      bg_r    <= 16'h0000;
      scale_r <= 4'd1;
      wrap_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FG_COLOR:    fg_r    <= cfg_wdata;
        REG_BG_COLOR:    bg_r    <= cfg_wdata;
        REG_TEXT_SCALE:  scale_r <= cfg_wdata[3:0];
        REG_WRAP_ENABLE: wrap_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Scale multiples built from shifts and adds.
  assign s    = (scale_r == 4'd0) ? 4'd1 : scale_r;
  assign s5   = {1'b0, s, 2'b00} + {3'b000, s};
  assign s6   = {1'b0, s, 2'b00} + {2'b00, s, 1'b0};
  assign s7p3 = {s, 3'b000} - {3'b000, s} + 7'd3;

  // Line wrap at the right edge.
  assign col_sum  = {1'b0, col_r} + {2'b00, s5};
  assign row_sum  = {1'b0, row_r} + {2'b00, s7p3};
  assign wrap_hit = wrap_r && (col_sum > SW9);
  assign row_wr   = (row_sum > SH9) ? SH8 : row_sum[7:0];
  assign col_eff  = wrap_hit ? 8'd0 : col_r;
  assign row_eff  = wrap_hit ? row_wr : row_r;
  assign adv_sum  = {1'b0, col_r} + {2'b00, s6};

  // Font slot; unprintable codes draw as a question mark.
  assign glyph_idx = ((code_r < CHAR_SPACE) || (code_r > CHAR_TILDE)) ? GLYPH_FALLBACK :
                     7'(code_r - CHAR_SPACE);

  // Current dot and its clipped rectangle.
  assign dot_bit    = gbits_r[0];
  assign have_color = dot_bit || (bg_r != fg_r);
  assign on_screen  = (px_r < SW9) && (py_r < SH9);
  assign cand       = have_color && on_screen;
  assign wrem       = SW9 - px_r;
  assign hrem       = SH9 - py_r;

  always_comb begin
    cand_rect.x     = px_r[7:0];
    cand_rect.y     = py_r[6:0];
    cand_rect.w     = (wrem > {5'b00000, s}) ? s : wrem[3:0];
    cand_rect.h     = (hrem > {5'b00000, s}) ? s : hrem[3:0];
    cand_rect.color = dot_bit ? fg_r : bg_r;
  end

  // Stepping and output hand-off.
  assign out_free   = !out_v_r || out_tready;
  assign step       = cmd.draw && (!cand || !pend_v_r || out_free);
  assign flush_emit = cmd.flush && pend_v_r && out_free;
  assign out_load   = (step && cand && pend_v_r) || flush_emit;

  // Cursor update.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept && in_tuser) begin
      col_nxt = in_tdata[15:8];
      row_nxt = in_tdata[23:16];
    end else if (cmd.prep) begin
      col_nxt = col_eff;
      row_nxt = row_eff;
    end else if (cmd.adv) begin
      col_nxt = (adv_sum > SW9) ? SW8 : adv_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Character latch and dot walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r    <= 6'd0;
      dotrow_r <= 3'd0;
    end else if (cmd.prep) begin
      dot_r    <= 6'd0;
      dotrow_r <= 3'd0;
    end else if (step) begin
      dot_r <= dot_r + 6'd1;
      if (dotrow_r == LAST_ROW) begin
        dotrow_r <= 3'd0;
      end else begin
        dotrow_r <= dotrow_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r <= in_tdata[7:0];
    end
    if (cmd.prep) begin
      gbits_r <= glyph_bits(glyph_idx);
      px_r    <= {1'b0, col_eff};
      py_r    <= {1'b0, row_eff};
    end else if (step) begin
      gbits_r <= {1'b0, gbits_r[34:1]};
      if (dotrow_r == LAST_ROW) begin
        px_r <= px_r + {5'b00000, s};
        py_r <= {1'b0, row_r};
      end else begin
        py_r <= py_r + {5'b00000, s};
      end
    end
  end

  // Held rectangle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (step && cand) begin
      pend_v_r <= 1'b1;
    end else if (flush_emit) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cand) begin
      pend_r <= cand_rect;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r      <= pend_r;
      out_last_r <= flush_emit;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r};
  assign out_tlast  = out_last_r;

  // Status to the controller.
  assign sts.skip       = wrap_hit && (code_r == CHAR_SPACE);
  assign sts.visible    = ({1'b0, col_eff} < SW9) && ({1'b0, row_eff} < SH9);
  assign sts.step_ok    = !cand || !pend_v_r || out_free;
  assign sts.last_dot   = (dot_r == LAST_DOT);
  assign sts.flush_done = !pend_v_r || out_free;

  // A new character never finds a rectangle left over from the previous one.
  a_no_stale_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !pend_v_r)
    else $error("held rectangle left over at character start");

  // The output register is only loaded when it is free.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");

  // The cursor advance only happens once the held rectangle has gone out.
  a_adv_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> !pend_v_r)
    else $error("cursor advanced with a rectangle still held");

  // The last tagged rectangle comes from the flush, after all dots were walked.
  a_flush_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    flush_emit |-> (dot_r == 6'(GLYPH_DOTS)))
    else $error("last rectangle sent before the glyph walk finished");

endmodule

[tb/tgr_rect_checker.sv]
`timescale 1ns / 1ps

module tgr_rect_checker
  import tgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], start_x[15:8], start_y[23:16]
  input  logic        in_tuser,   // start_req[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // rect_x[7:0], rect_y[14:8], rect_width[18:15],
                                  // rect_height[22:19], rect_color[38:23], zero[39]
  input  logic        out_tlast,
  output int          fault_count,
  output int          rects_owed
);

  // Unprintable codes are drawn with the question mark glyph.
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  typedef struct packed {
    logic [7:0]  x;
    logic [6:0]  y;
    logic [3:0]  w;
    logic [3:0]  h;
    logic [15:0] color;
    logic        last;
  } rect_t;

  // Font columns for space through tilde, five per glyph; bit 0 is the top row.
  logic [6:0] font_cols [0:474] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5F, 7'h00, 7'h00,
    7'h00, 7'h07, 7'h00, 7'h07, 7'h00, 7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14,
    7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12, 7'h23, 7'h13, 7'h08, 7'h64, 7'h62,
    7'h36, 7'h49, 7'h56, 7'h20, 7'h50, 7'h00, 7'h08, 7'h07, 7'h03, 7'h00,
    7'h00, 7'h1C, 7'h22, 7'h41, 7'h00, 7'h00, 7'h41, 7'h22, 7'h1C, 7'h00,
    7'h2A, 7'h1C, 7'h7F, 7'h1C, 7'h2A, 7'h08, 7'h08, 7'h3E, 7'h08, 7'h08,
    7'h00, 7'h00, 7'h70, 7'h30, 7'h00, 7'h08, 7'h08, 7'h08, 7'h08, 7'h08,
    7'h00, 7'h00, 7'h60, 7'h60, 7'h00, 7'h20, 7'h10, 7'h08, 7'h04, 7'h02,
    7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E, 7'h00, 7'h42, 7'h7F, 7'h40, 7'h00,
    7'h72, 7'h49, 7'h49, 7'h49, 7'h46, 7'h21, 7'h41, 7'h49, 7'h4D, 7'h33,
    7'h18, 7'h14, 7'h12, 7'h7F, 7'h10, 7'h27, 7'h45, 7'h45, 7'h45, 7'h39,
    7'h3C, 7'h4A, 7'h49, 7'h49, 7'h31, 7'h41, 7'h21, 7'h11, 7'h09, 7'h07,
    7'h36, 7'h49, 7'h49, 7'h49, 7'h36, 7'h46, 7'h49, 7'h49, 7'h29, 7'h1E,
    7'h00, 7'h00, 7'h14, 7'h00, 7'h00, 7'h00, 7'h40, 7'h34, 7'h00, 7'h00,
    7'h00, 7'h08, 7'h14, 7'h22, 7'h41, 7'h14, 7'h14, 7'h14, 7'h14, 7'h14,
    7'h00, 7'h41, 7'h22, 7'h14, 7'h08, 7'h02, 7'h01, 7'h59, 7'h09, 7'h06,
    7'h3E, 7'h41, 7'h5D, 7'h59, 7'h4E, 7'h7C, 7'h12, 7'h11, 7'h12, 7'h7C,
    7'h7F, 7'h49, 7'h49, 7'h49, 7'h36, 7'h3E, 7'h41, 7'h41, 7'h41, 7'h22,
    7'h7F, 7'h41, 7'h41, 7'h41, 7'h3E, 7'h7F, 7'h49, 7'h49, 7'h49, 7'h41,
    7'h7F, 7'h09, 7'h09, 7'h09, 7'h01, 7'h3E, 7'h41, 7'h41, 7'h51, 7'h73,
    7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F, 7'h00, 7'h41, 7'h7F, 7'h41, 7'h00,
    7'h20, 7'h40, 7'h41, 7'h3F, 7'h01, 7'h7F, 7'h08, 7'h14, 7'h22, 7'h41,
    7'h7F, 7'h40, 7'h40, 7'h40, 7'h40, 7'h7F, 7'h02, 7'h1C, 7'h02, 7'h7F,
    7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F, 7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E,
    7'h7F, 7'h09, 7'h09, 7'h09, 7'h06, 7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E,
    7'h7F, 7'h09, 7'h19, 7'h29, 7'h46, 7'h26, 7'h49, 7'h49, 7'h49, 7'h32,
    7'h03, 7'h01, 7'h7F, 7'h01, 7'h03, 7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F,
    7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F, 7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F,
    7'h63, 7'h14, 7'h08, 7'h14, 7'h63, 7'h03, 7'h04, 7'h78, 7'h04, 7'h03,
    7'h61, 7'h59, 7'h49, 7'h4D, 7'h43, 7'h00, 7'h7F, 7'h41, 7'h41, 7'h41,
    7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h00, 7'h41, 7'h41, 7'h41, 7'h7F,
    7'h04, 7'h02, 7'h01, 7'h02, 7'h04, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40,
    7'h00, 7'h03, 7'h07, 7'h08, 7'h00, 7'h20, 7'h54, 7'h54, 7'h78, 7'h40,
    7'h7F, 7'h28, 7'h44, 7'h44, 7'h38, 7'h38, 7'h44, 7'h44, 7'h44, 7'h28,
    7'h38, 7'h44, 7'h44, 7'h28, 7'h7F, 7'h38, 7'h54, 7'h54, 7'h54, 7'h18,
    7'h00, 7'h08, 7'h7E, 7'h09, 7'h02, 7'h18, 7'h24, 7'h24, 7'h1C, 7'h78,
    7'h7F, 7'h08, 7'h04, 7'h04, 7'h78, 7'h00, 7'h44, 7'h7D, 7'h40, 7'h00,
    7'h20, 7'h40, 7'h40, 7'h3D, 7'h00, 7'h7F, 7'h10, 7'h28, 7'h44, 7'h00,
    7'h00, 7'h41, 7'h7F, 7'h40, 7'h00, 7'h7C, 7'h04, 7'h78, 7'h04, 7'h78,
    7'h7C, 7'h08, 7'h04, 7'h04, 7'h78, 7'h38, 7'h44, 7'h44, 7'h44, 7'h38,
    7'h7C, 7'h18, 7'h24, 7'h24, 7'h18, 7'h18, 7'h24, 7'h24, 7'h18, 7'h7C,
    7'h7C, 7'h08, 7'h04, 7'h04, 7'h08, 7'h48, 7'h54, 7'h54, 7'h54, 7'h24,
    7'h04, 7'h04, 7'h3F, 7'h44, 7'h24, 7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C,
    7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C, 7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C,
    7'h44, 7'h28, 7'h10, 7'h28, 7'h44, 7'h4C, 7'h10, 7'h10, 7'h10, 7'h7C,
    7'h44, 7'h64, 7'h54, 7'h4C, 7'h44, 7'h00, 7'h08, 7'h36, 7'h41, 7'h00,
    7'h00, 7'h00, 7'h77, 7'h00, 7'h00, 7'h00, 7'h41, 7'h36, 7'h08, 7'h00,
    7'h02, 7'h01, 7'h02, 7'h04, 7'h02
  };

  // Shadow copy of the registers and the text cursor.
  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic [3:0]  text_scale;
  logic        wrap_on;
  int          cur_col;
  int          cur_row;

  rect_t rect_q [$];
  rect_t got_rect;
  rect_t want_rect;

  // Computes the rectangles one character produces and queues them in order.
  task automatic render_char(input logic [7:0] code, input logic load,
                             input logic [7:0] load_x, input logic [7:0] load_y);
    int          s;
    int          nxt;
    int          idx;
    int          px;
    int          py;
    int          n;
    logic [6:0]  bits;
    logic        paint;
    logic        skip;
    rect_t       r_new;
    s = (text_scale == 4'd0) ? 1 : int'(text_scale);
    n = 0;
    skip = 1'b0;
    if (load) begin
      cur_col = int'(load_x);
      cur_row = int'(load_y);
    end
    // Wrap to the next line when the glyph would pass the right edge.
    if (wrap_on && (cur_col + 5 * s > SCREEN_WIDTH)) begin
      cur_col = 0;
      nxt = cur_row + 7 * s + 3;
      cur_row = (nxt > SCREEN_HEIGHT) ? SCREEN_HEIGHT : nxt;
      skip = (code == CHAR_SPACE);
    end
    if (!skip) begin
      idx = (code < CHAR_SPACE || code > CHAR_TILDE) ? int'(CHAR_QMARK) : int'(code);
      idx = idx - int'(CHAR_SPACE);
      // A glyph whose origin is off screen draws nothing.
      if (cur_col < SCREEN_WIDTH && cur_row < SCREEN_HEIGHT) begin
        for (int c = 0; c < 5; c++) begin
          bits = font_cols[idx * 5 + c];
          px = cur_col + c * s;
          for (int r = 0; r < FONT_ROWS; r++) begin
            py = cur_row + r * s;
            paint = 1'b1;
            if (bits[r]) begin
              r_new.color = fg_color;
            end else if (bg_color != fg_color) begin
              r_new.color = bg_color;
            end else begin
              paint = 1'b0;
            end
            if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) begin
              paint = 1'b0;
            end
            if (paint) begin
              r_new.x = 8'(px);
              r_new.y = 7'(py);
              r_new.w = 4'((SCREEN_WIDTH - px > s) ? s : SCREEN_WIDTH - px);
              r_new.h = 4'((SCREEN_HEIGHT - py > s) ? s : SCREEN_HEIGHT - py);
              r_new.last = 1'b0;
              rect_q.push_back(r_new);
              n++;
            end
          end
        end
        if (n > 0) begin
          rect_q[rect_q.size() - 1].last = 1'b1;
        end
      end
      nxt = cur_col + 6 * s;
      cur_col = (nxt > SCREEN_WIDTH) ? SCREEN_WIDTH : nxt;
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  // Compare each output transaction, track register writes, then predict for
  // each input transaction, all on the values present before the clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      fg_color   = 16'hFFFF;
      bg_color   = 16'h0000;
      text_scale = 4'd1;
      wrap_on    = 1'b1;
      cur_col    = 0;
      cur_row    = 0;
      rect_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_rect.x     = out_tdata[7:0];
        got_rect.y     = out_tdata[14:8];
        got_rect.w     = out_tdata[18:15];
        got_rect.h     = out_tdata[22:19];
        got_rect.color = out_tdata[38:23];
        got_rect.last  = out_tlast;
        if (rect_q.size() == 0) begin
          $error("unexpected rectangle: x=%0d y=%0d w=%0d h=%0d color=%0h last=%0b",
                 got_rect.x, got_rect.y, got_rect.w, got_rect.h, got_rect.color,
                 got_rect.last);
          fault_count++;
        end else begin
          want_rect = rect_q.pop_front();
          compare_field("rect_x", 16'(want_rect.x), 16'(got_rect.x));
          compare_field("rect_y", 16'(want_rect.y), 16'(got_rect.y));
          compare_field("rect_width", 16'(want_rect.w), 16'(got_rect.w));
          compare_field("rect_height", 16'(want_rect.h), 16'(got_rect.h));
          compare_field("rect_color", want_rect.color, got_rect.color);
          compare_field("last", 16'(want_rect.last), 16'(got_rect.last));
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_FG_COLOR:    fg_color   = cfg_wdata;
          REG_BG_COLOR:    bg_color   = cfg_wdata;
          REG_TEXT_SCALE:  text_scale = cfg_wdata[3:0];
          REG_WRAP_ENABLE: wrap_on    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        render_char(in_tdata[7:0], in_tuser, in_tdata[15:8], in_tdata[23:16]);
      end
    end
    rects_owed <= rect_q.size();
  end

endmodule

[tb/text_glyph_rasterizer_unit_tb.sv]
`timescale 1ns / 1ps

module text_glyph_rasterizer_unit_tb;
  import tgr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // char_code[7:0], start_x[15:8], start_y[23:16]
  logic        in_tuser;   // start_req[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // rect_x[7:0], rect_y[14:8], rect_width[18:15],
                           // rect_height[22:19], rect_color[38:23], zero[39]
  logic        out_tlast;

  int   fault_count;
  int   rects_owed;
  logic no_idle;

  text_glyph_rasterizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  tgr_rect_checker rect_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fault_count (fault_count),
    .rects_owed  (rects_owed)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: a random stall before each output transaction.
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  // Presents one character after a random gap and holds it until the
  // transaction completes; valid stays high for a back-to-back follower.
  task automatic send_char(input logic [7:0] code, input logic load,
                           input logic [7:0] x, input logic [7:0] y);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x, code};
    in_tuser  <= load;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops the input and waits until every rectangle has arrived, plus enough
  // cycles for a character that draws nothing to finish.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rects_owed != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles; unused upper bits are random.
  task automatic set_config(input logic [15:0] fg, input logic [15:0] bg,
                            input logic [3:0] scale, input logic wrap);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FG_COLOR;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_addr  <= REG_BG_COLOR;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_addr  <= REG_TEXT_SCALE;
    cfg_wdata <= {12'($urandom), scale};
    @(posedge clk);
    cfg_addr  <= REG_WRAP_ENABLE;
    cfg_wdata <= {15'($urandom), wrap};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A run of characters, usually opened with a new start position.
  task automatic random_string(input int len);
    logic [7:0] code;
    logic [7:0] x;
    logic [7:0] y;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        code = CHAR_SPACE;
      end else if (pick < 16) begin
        code = 8'($urandom_range(0, 31));
      end else if (pick < 20) begin
        code = 8'($urandom_range(127, 255));
      end else begin
        code = 8'($urandom_range(33, 126));
      end
      if (i == 0 && $urandom_range(0, 6) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) x = 8'($urandom_range(0, 159));
        else if (pick < 17) x = 8'($urandom_range(140, 165));
        else x = 8'($urandom);
        y = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 127)) : 8'($urandom);
        send_char(code, 1'b1, x, y);
      end else begin
        send_char(code, 1'b0, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int          sent;
    int          len;
    logic [3:0]  scale;
    logic [15:0] fg;
    logic [15:0] bg;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_FG_COLOR;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    no_idle   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: white on black, scale 1, wrap on.
    send_char("A", 1'b1, 8'd0, 8'd0);
    send_char(8'h00, 1'b0, 8'hFF, 8'hAA);
    send_char(8'hFF, 1'b0, 8'h55, 8'h00);
    send_char(8'h1F, 1'b0, 8'h00, 8'h00);
    send_char(8'h7F, 1'b0, 8'h00, 8'h00);
    send_char(CHAR_TILDE, 1'b0, 8'h00, 8'h00);
    send_char(CHAR_SPACE, 1'b0, 8'h00, 8'h00);
    // Wrap at the right edge, and a space dropped at a wrap.
    send_char("W", 1'b1, 8'd156, 8'd0);
    send_char(CHAR_SPACE, 1'b1, 8'd158, 8'd20);
    // Bottom edge clipping; a glyph that just fits the right edge.
    send_char("H", 1'b1, 8'd0, 8'd125);
    send_char("#", 1'b1, 8'd155, 8'd127);
    wait_idle();

    // Scale zero, wrap off, equal colors so clear dots are not drawn.
    set_config(16'h1234, 16'h1234, 4'd0, 1'b0);
    send_char("M", 1'b1, 8'd157, 8'd0);
    send_char(CHAR_SPACE, 1'b1, 8'd10, 8'd10);
    send_char("A", 1'b1, 8'd200, 8'd10);
    send_char("B", 1'b1, 8'd0, 8'd200);
    send_char("C", 1'b1, 8'd255, 8'd255);
    wait_idle();

    // Largest scale with wrap: big dots, wrap past the bottom, clipped sizes.
    set_config(16'h0000, 16'hFFFF, 4'd15, 1'b1);
    send_char("@", 1'b1, 8'd0, 8'd0);
    send_char("&", 1'b0, 8'd0, 8'd0);
    send_char("g", 1'b1, 8'd150, 8'd120);
    wait_idle();
    set_config(16'hFFFF, 16'h0000, 4'd15, 1'b0);
    send_char("Q", 1'b1, 8'd100, 8'd100);
    send_char("%", 1'b0, 8'd0, 8'd0);

    // Random phases; the input drains fully before each new setting.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       scale = 4'd0;
        1:       scale = 4'd15;
        2, 3:    scale = 4'd1;
        4:       scale = 4'd2;
        5:       scale = 4'd3;
        default: scale = 4'($urandom_range(0, 15));
      endcase
      fg = 16'($urandom);
      bg = ($urandom_range(0, 3) == 0) ? fg : 16'($urandom);
      set_config(fg, bg, scale, 1'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 20) begin
        len = $urandom_range(1, 12);
        random_string(len);
        sent += len;
      end
    end
    no_idle = 1'b0;
    wait_idle();

    if (fault_count == 0 && rects_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
